@@ rtl/core/ogt_pkg.sv @@
// Shared types, codes and reset values for the orientation gesture tracker.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package ogt_pkg;

	localparam int AXIS_W      = 16;
	localparam int MAG_W       = AXIS_W + 1;
	localparam int TIME_W      = 64;
	localparam int LEVEL_W     = 15;
	localparam int DWELL_W     = 24;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;
	localparam int IN_TDATA_W  = 3 * AXIS_W + TIME_W;
	localparam int OUT_TDATA_W = 8;

	localparam logic [LEVEL_W-1:0] FLAT_ENTER_RST = 15'd3482;
	localparam logic [LEVEL_W-1:0] FLAT_EXIT_RST  = 15'd3072;
	localparam logic [LEVEL_W-1:0] VERTICAL_RST   = 15'd2896;
	localparam logic [LEVEL_W-1:0] SIDE_RST       = 15'd2896;
	localparam logic [DWELL_W-1:0] DWELL_RST      = 24'd350000;
	localparam logic [DWELL_W-1:0] SIDE_DWELL_RST = 24'd1000000;

	typedef enum logic [2:0] {
		POS_UNKNOWN   = 3'd0,
		POS_FLATBACK  = 3'd1,
		POS_FACEDOWN  = 3'd2,
		POS_UPRIGHT_A = 3'd3,
		POS_UPRIGHT_B = 3'd4,
		POS_SIDE      = 3'd5,
		POS_EDGE      = 3'd6
	} posture_t;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_FLIP    = 3'd1,
		EV_RAISED  = 3'd2,
		EV_RIGHTED = 3'd3,
		EV_SETTLED = 3'd4,
		EV_SILENCE = 3'd5,
		EV_TIPPED  = 3'd6
	} motion_event_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FLAT_ENTER = 3'd0,
		REG_FLAT_EXIT  = 3'd1,
		REG_VERTICAL   = 3'd2,
		REG_SIDE       = 3'd3,
		REG_DWELL      = 3'd4,
		REG_SIDE_DWELL = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] flat_enter_level;
		logic [LEVEL_W-1:0] flat_exit_level;
		logic [LEVEL_W-1:0] vertical_level;
		logic [LEVEL_W-1:0] side_level;
		logic [DWELL_W-1:0] dwell_time;
		logic [DWELL_W-1:0] side_dwell_time;
	} cfg_t;

endpackage

`default_nettype wire

@@ rtl/core/ogt_cfg_regs.sv @@
// Configuration register file: six thresholds and hold times written by index.
// Depends on ogt_pkg.
`default_nettype none

module ogt_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               wr_en,
	input  wire logic [ogt_pkg::CFG_INDEX_W-1:0]    wr_index,
	input  wire logic [ogt_pkg::CFG_DATA_W-1:0]     wr_data,
	output ogt_pkg::cfg_t                           cfg
);
	import ogt_pkg::*;

	cfg_t cfg_q;

	// Indexes past the last register are dropped without effect.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flat_enter_level <= FLAT_ENTER_RST;
			cfg_q.flat_exit_level  <= FLAT_EXIT_RST;
			cfg_q.vertical_level   <= VERTICAL_RST;
			cfg_q.side_level       <= SIDE_RST;
			cfg_q.dwell_time       <= DWELL_RST;
			cfg_q.side_dwell_time  <= SIDE_DWELL_RST;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_FLAT_ENTER: cfg_q.flat_enter_level <= wr_data[LEVEL_W-1:0];
				REG_FLAT_EXIT:  cfg_q.flat_exit_level  <= wr_data[LEVEL_W-1:0];
				REG_VERTICAL:   cfg_q.vertical_level   <= wr_data[LEVEL_W-1:0];
				REG_SIDE:       cfg_q.side_level       <= wr_data[LEVEL_W-1:0];
				REG_DWELL:      cfg_q.dwell_time       <= wr_data[DWELL_W-1:0];
				REG_SIDE_DWELL: cfg_q.side_dwell_time  <= wr_data[DWELL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ rtl/core/ogt_classify.sv @@
// Combinational posture classifier for one gravity sample, with flat hysteresis.
// Depends on ogt_pkg.
`default_nettype none

module ogt_classify (
	input  wire logic [ogt_pkg::AXIS_W-1:0] accel_x,
	input  wire logic [ogt_pkg::AXIS_W-1:0] accel_y,
	input  wire logic [ogt_pkg::AXIS_W-1:0] accel_z,
	input  wire ogt_pkg::cfg_t              cfg,
	input  wire ogt_pkg::posture_t          committed,
	output ogt_pkg::posture_t               seen
);
	import ogt_pkg::*;

	// One extra bit so that the most negative input has a positive magnitude.
	function automatic logic [MAG_W-1:0] mag(input logic [AXIS_W-1:0] v);
		logic [MAG_W-1:0] ext;
		ext = {v[AXIS_W-1], v};
		return v[AXIS_W-1] ? (~ext + MAG_W'(1)) : ext;
	endfunction

	logic [MAG_W-1:0]   ax, ay, az;
	logic [LEVEL_W-1:0] flat_th;
	logic               is_flat;

	always_comb begin
		ax      = mag(accel_x);
		ay      = mag(accel_y);
		az      = mag(accel_z);
		is_flat = (committed == POS_FLATBACK) || (committed == POS_FACEDOWN);
		flat_th = is_flat ? cfg.flat_exit_level : cfg.flat_enter_level;
		if (az >= MAG_W'(flat_th)) begin
			seen = accel_z[AXIS_W-1] ? POS_FLATBACK : POS_FACEDOWN;
		end else if ((ay >= MAG_W'(cfg.vertical_level)) && (ay > ax)) begin
			// ay > ax rules out a zero y, so the sign bit alone picks the side.
			seen = accel_y[AXIS_W-1] ? POS_UPRIGHT_B : POS_UPRIGHT_A;
		end else if ((ax >= MAG_W'(cfg.side_level)) && (ax > ay)) begin
			seen = POS_SIDE;
		end else begin
			seen = POS_EDGE;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/ogt_commit.sv @@
// Dwell timer and commit logic: candidate tracking, committed posture, flip arming.
// Depends on ogt_pkg.
`default_nettype none

module ogt_commit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      step,
	input  wire ogt_pkg::posture_t         seen,
	input  wire logic [ogt_pkg::TIME_W-1:0] time_us,
	input  wire ogt_pkg::cfg_t             cfg,
	output ogt_pkg::posture_t              committed,
	output ogt_pkg::motion_event_t         motion_event,
	output ogt_pkg::posture_t              posture
);
	import ogt_pkg::*;

	posture_t            committed_q, candidate_q, last_upright_q;
	logic [TIME_W-1:0]   cand_start_q;
	logic                flip_armed_q;

	posture_t            committed_d, candidate_d, last_upright_d;
	logic [TIME_W-1:0]   cand_start_d;
	logic                flip_armed_d;
	motion_event_t       ev;
	logic [TIME_W-1:0]   elapsed;
	logic [DWELL_W-1:0]  need;
	logic                flip;

	always_comb begin
		committed_d    = committed_q;
		candidate_d    = candidate_q;
		last_upright_d = last_upright_q;
		cand_start_d   = cand_start_q;
		flip_armed_d   = flip_armed_q;
		ev             = EV_NONE;
		// Elapsed time wraps, so a timestamp that runs backwards commits.
		elapsed        = time_us - cand_start_q;
		need           = (seen == POS_SIDE) ? cfg.side_dwell_time : cfg.dwell_time;
		flip           = flip_armed_q && (last_upright_q != POS_UNKNOWN)
		                 && (last_upright_q != seen);
		if (seen != candidate_q) begin
			candidate_d  = seen;
			cand_start_d = time_us;
		end else if ((seen != committed_q) && (elapsed >= TIME_W'(need))) begin
			committed_d = seen;
			case (seen)
				POS_UPRIGHT_A, POS_UPRIGHT_B: begin
					last_upright_d = seen;
					flip_armed_d   = 1'b1;
					if (flip) begin
						ev = EV_FLIP;
					end else if (committed_q == POS_FLATBACK) begin
						ev = EV_RAISED;
					end else if ((committed_q == POS_SIDE) || (committed_q == POS_EDGE)) begin
						ev = EV_RIGHTED;
					end
				end
				POS_FLATBACK: begin
					flip_armed_d = 1'b0;
					ev           = EV_SETTLED;
				end
				POS_FACEDOWN: begin
					flip_armed_d = 1'b0;
					ev           = EV_SILENCE;
				end
				POS_SIDE: begin
					ev = (committed_q == POS_UNKNOWN) ? EV_NONE : EV_TIPPED;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			committed_q    <= POS_UNKNOWN;
			candidate_q    <= POS_UNKNOWN;
			last_upright_q <= POS_UNKNOWN;
			cand_start_q   <= '0;
			flip_armed_q   <= 1'b0;
		end else if (step) begin
			committed_q    <= committed_d;
			candidate_q    <= candidate_d;
			last_upright_q <= last_upright_d;
			cand_start_q   <= cand_start_d;
			flip_armed_q   <= flip_armed_d;
		end
	end

	assign committed    = committed_q;
	assign motion_event = ev;
	assign posture      = committed_d;

endmodule

`default_nettype wire

@@ rtl/core/orientation_gesture_tracker.sv @@
// Orientation gesture tracker: samples in, one posture and motion event out per sample.
// Depends on ogt_pkg, ogt_cfg_regs, ogt_classify and ogt_commit.
//
// Usage:
//   The sample channel (s_axis_*) carries one gravity sample per transaction. Each
//   accepted sample yields exactly one result transaction on m_axis_*, in order.
//   The configuration channel (cfg_*) writes one register per transaction and is
//   always ready; write it only while no sample is in flight.
// Pipeline and throughput:
//   A sample accepted into the input register is classified and committed
//   combinationally; the commit state and the result register load together when
//   it advances. One sample per cycle is sustained while m_axis_tready stays high;
//   the limit is the single commit step, whose state update (posture, candidate,
//   64-bit dwell start) must finish before the next sample is classified.
// Stalls:
//   While the result register is full and m_axis_tready is low, the input register
//   still takes one more sample, then s_axis_tready drops until a result drains.
// Reset:
//   arst_n clears the valid bits of both stages and the tracking state, and loads the default thresholds.
`default_nettype none

module orientation_gesture_tracker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output      logic                               s_axis_tready,
	// accel_x [15:0], accel_y [31:16], accel_z [47:32], time_us [111:48]
	input  wire logic [ogt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output      logic                               m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// motion_event [2:0], posture [5:3], zero [7:6]
	output      logic [ogt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  wire logic                               cfg_valid,
	output      logic                               cfg_ready,
	input  wire logic [ogt_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [ogt_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import ogt_pkg::*;

	cfg_t              cfg;
	logic              valid_s1;
	logic [AXIS_W-1:0] accel_x_s1, accel_y_s1, accel_z_s1;
	logic [TIME_W-1:0] time_us_s1;
	logic              advance;
	logic              s_accept;
	posture_t          committed, seen, posture_nxt;
	motion_event_t     event_nxt;
	logic              out_valid_q;
	motion_event_t     event_q;
	posture_t          posture_q;

	assign cfg_ready = 1'b1;

	ogt_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			accel_x_s1 <= s_axis_tdata[AXIS_W-1:0];
			accel_y_s1 <= s_axis_tdata[2*AXIS_W-1:AXIS_W];
			accel_z_s1 <= s_axis_tdata[3*AXIS_W-1:2*AXIS_W];
			time_us_s1 <= s_axis_tdata[3*AXIS_W+TIME_W-1:3*AXIS_W];
		end
	end

	ogt_classify u_classify (
		.accel_x   (accel_x_s1),
		.accel_y   (accel_y_s1),
		.accel_z   (accel_z_s1),
		.cfg       (cfg),
		.committed (committed),
		.seen      (seen)
	);

	ogt_commit u_commit (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.seen         (seen),
		.time_us      (time_us_s1),
		.cfg          (cfg),
		.committed    (committed),
		.motion_event (event_nxt),
		.posture      (posture_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q   <= event_nxt;
			posture_q <= posture_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, posture_q, event_q};

endmodule

`default_nettype wire

@@ rtl/core/ogt_checker.sv @@
// Port-level checks for orientation_gesture_tracker, bound to the top level.
// Depends on ogt_pkg and the top level's port list.
`default_nettype none

module ogt_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               s_axis_tvalid,
	input wire logic                               s_axis_tready,
	input wire logic                               m_axis_tvalid,
	input wire logic                               m_axis_tready,
	input wire logic [ogt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
	import ogt_pkg::*;

	logic [2:0] ev;
	logic [2:0] pos;

	assign ev  = m_axis_tdata[2:0];
	assign pos = m_axis_tdata[5:3];

	// A stalled result transaction keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// With the result register empty the sample side must not stall.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("sample side stalled with empty output");

	// Flip, raised and righted events only land in an upright posture.
	a_upright_events: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (ev == EV_FLIP || ev == EV_RAISED || ev == EV_RIGHTED)
		|-> (pos == POS_UPRIGHT_A || pos == POS_UPRIGHT_B))
		else $error("upright event without upright posture");

	// Settled, silence and tipped each belong to exactly one posture.
	a_rest_events: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (ev != EV_SETTLED || pos == POS_FLATBACK)
		&& (ev != EV_SILENCE || pos == POS_FACEDOWN)
		&& (ev != EV_TIPPED || pos == POS_SIDE))
		else $error("event does not match committed posture");

	// No result may appear unless a sample was taken before it.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready || (s_axis_tvalid && s_axis_tready), 2)
		|| $past(!m_axis_tready, 2) || $past(m_axis_tvalid, 2) || $past(s_axis_tvalid, 2))
		else $error("result appeared without a sample");

endmodule

bind orientation_gesture_tracker ogt_checker u_ogt_checker (.*);

`default_nettype wire

@@ tb/orientation_gesture_tracker_tb.sv @@
`timescale 1ns / 1ps
// Testbench for orientation_gesture_tracker: directed and random gravity samples,
// with a scoreboard class that predicts the posture and motion event of each sample.
// Depends on ogt_pkg and the orientation_gesture_tracker RTL.

import ogt_pkg::*;

class posture_scoreboard;
	logic [LEVEL_W-1:0] flat_enter;
	logic [LEVEL_W-1:0] flat_keep;
	logic [LEVEL_W-1:0] vertical;
	logic [LEVEL_W-1:0] side;
	logic [DWELL_W-1:0] dwell;
	logic [DWELL_W-1:0] side_dwell;

	posture_t committed;
	posture_t candidate;
	posture_t last_upright;
	logic [TIME_W-1:0] candidate_start;
	bit armed;

	logic [OUT_TDATA_W-1:0] awaited_reports[$];
	int mismatches;

	function new();
		flat_enter = FLAT_ENTER_RST;
		flat_keep = FLAT_EXIT_RST;
		vertical = VERTICAL_RST;
		side = SIDE_RST;
		dwell = DWELL_RST;
		side_dwell = SIDE_DWELL_RST;
		committed = POS_UNKNOWN;
		candidate = POS_UNKNOWN;
		last_upright = POS_UNKNOWN;
		candidate_start = '0;
		armed = 1'b0;
		mismatches = 0;
	endfunction

	function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		case (index)
		REG_FLAT_ENTER: flat_enter = data[LEVEL_W-1:0];
		REG_FLAT_EXIT: flat_keep = data[LEVEL_W-1:0];
		REG_VERTICAL: vertical = data[LEVEL_W-1:0];
		REG_SIDE: side = data[LEVEL_W-1:0];
		REG_DWELL: dwell = data[DWELL_W-1:0];
		REG_SIDE_DWELL: side_dwell = data[DWELL_W-1:0];
		default: ;
		endcase
	endfunction

	function logic [MAG_W-1:0] magnitude(logic [AXIS_W-1:0] v);
		logic [MAG_W-1:0] wide;
		wide = {v[AXIS_W-1], v};
		return wide[MAG_W-1] ? -wide : wide;
	endfunction

	function posture_t grade_axes(logic [AXIS_W-1:0] x, logic [AXIS_W-1:0] y,
			logic [AXIS_W-1:0] z);
		logic [MAG_W-1:0] ax;
		logic [MAG_W-1:0] ay;
		logic [MAG_W-1:0] az;
		logic [LEVEL_W-1:0] flat_level;
		ax = magnitude(x);
		ay = magnitude(y);
		az = magnitude(z);
		// Hysteresis: staying flat needs only the lower exit level.
		flat_level = (committed == POS_FLATBACK || committed == POS_FACEDOWN) ?
			flat_keep : flat_enter;
		if (az >= MAG_W'(flat_level))
			return z[AXIS_W-1] ? POS_FLATBACK : POS_FACEDOWN;
		if (ay >= MAG_W'(vertical) && ay > ax)
			return (!y[AXIS_W-1] && y != '0) ? POS_UPRIGHT_A : POS_UPRIGHT_B;
		if (ax >= MAG_W'(side) && ax > ay)
			return POS_SIDE;
		return POS_EDGE;
	endfunction

	function void note_sample(logic [AXIS_W-1:0] x, logic [AXIS_W-1:0] y,
			logic [AXIS_W-1:0] z, logic [TIME_W-1:0] stamp);
		posture_t seen;
		posture_t prev;
		motion_event_t ev;
		logic [DWELL_W-1:0] need;
		logic [TIME_W-1:0] elapsed;
		seen = grade_axes(x, y, z);
		ev = EV_NONE;
		if (seen != candidate) begin
			candidate = seen;
			candidate_start = stamp;
		end else if (seen != committed) begin
			need = (seen == POS_SIDE) ? side_dwell : dwell;
			// Elapsed time wraps, so a timestamp that runs backwards commits at once.
			elapsed = stamp - candidate_start;
			if (elapsed >= TIME_W'(need)) begin
				prev = committed;
				committed = seen;
				case (seen)
				POS_UPRIGHT_A, POS_UPRIGHT_B: begin
					if (armed && last_upright != POS_UNKNOWN && last_upright != seen)
						ev = EV_FLIP;
					else if (prev == POS_FLATBACK)
						ev = EV_RAISED;
					else if (prev == POS_SIDE || prev == POS_EDGE)
						ev = EV_RIGHTED;
					last_upright = seen;
					armed = 1'b1;
				end
				POS_FLATBACK: begin
					armed = 1'b0;
					ev = EV_SETTLED;
				end
				POS_FACEDOWN: begin
					armed = 1'b0;
					ev = EV_SILENCE;
				end
				POS_SIDE: begin
					if (prev != POS_UNKNOWN)
						ev = EV_TIPPED;
				end
				default: ;
				endcase
			end
		end
		awaited_reports.push_back({2'b00, committed, ev});
	endfunction

	function void check_result(logic [OUT_TDATA_W-1:0] got);
		logic [OUT_TDATA_W-1:0] want;
		if (awaited_reports.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result at %0t: event %0d posture %0d", $realtime,
					got[2:0], got[5:3]);
			return;
		end
		want = awaited_reports.pop_front();
		if (got[2:0] !== want[2:0] || got[5:3] !== want[5:3] || got[7:6] !== want[7:6]) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch at %0t: event exp %0d got %0d, posture exp %0d got %0d, pad got %0d",
					$realtime, want[2:0], got[2:0], want[5:3], got[5:3], got[7:6]);
		end
	endfunction

	function int pending();
		return awaited_reports.size();
	endfunction
endclass

module orientation_gesture_tracker_tb;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	posture_scoreboard sb;
	logic [TIME_W-1:0] now_us = '0;
	bit hold_asked = 1'b0;
	bit hold_served = 1'b0;
	int quiet_cycles = 0;

	orientation_gesture_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic bit holding();
		return hold_asked && !hold_served;
	endfunction

	task automatic feed_sample(input int x, input int y, input int z,
			input logic [TIME_W-1:0] stamp);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {stamp, 16'(z), 16'(y), 16'(x)};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_sample(16'(x), 16'(y), 16'(z), stamp);
		// While the receiver is held off the sender keeps pushing to fill the block.
		gap = holding() ? 0 : idle_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(index, data);
	endtask

	// Registers change only once every sample in flight has produced its result.
	task automatic set_thresholds(input logic [CFG_DATA_W-1:0] enter_lvl,
			input logic [CFG_DATA_W-1:0] keep_lvl, input logic [CFG_DATA_W-1:0] vert_lvl,
			input logic [CFG_DATA_W-1:0] side_lvl, input logic [CFG_DATA_W-1:0] dw,
			input logic [CFG_DATA_W-1:0] side_dw);
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		write_reg(REG_FLAT_ENTER, enter_lvl);
		write_reg(REG_FLAT_EXIT, keep_lvl);
		write_reg(REG_VERTICAL, vert_lvl);
		write_reg(REG_SIDE, side_lvl);
		write_reg(REG_DWELL, dw);
		write_reg(REG_SIDE_DWELL, side_dw);
		cfg_valid <= 1'b0;
	endtask

	function automatic int big_axis(bit neg);
		int m;
		m = ($urandom_range(0, 3) == 0) ? 32768 : int'($urandom_range(2800, 32768));
		if (!neg && m > 32767)
			m = 32767;
		return neg ? -m : m;
	endfunction

	function automatic int small_axis();
		int m;
		m = $urandom_range(0, 1600);
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	task automatic shape_sample(input posture_t target, output int x, output int y,
			output int z);
		case (target)
		POS_FLATBACK, POS_FACEDOWN: begin
			x = small_axis();
			y = small_axis();
			z = big_axis(target == POS_FLATBACK);
		end
		POS_UPRIGHT_A, POS_UPRIGHT_B: begin
			x = small_axis();
			y = big_axis(target == POS_UPRIGHT_B);
			z = small_axis();
		end
		POS_SIDE: begin
			x = big_axis($urandom_range(0, 1));
			y = small_axis();
			z = small_axis();
		end
		default: begin
			// Edge postures, sometimes with |x| equal to |y|.
			x = int'($urandom_range(0, 6000)) - 3000;
			y = ($urandom_range(0, 3) == 0) ? -x : int'($urandom_range(0, 6000)) - 3000;
			z = int'($urandom_range(0, 6000)) - 3000;
		end
		endcase
	endtask

	// Episodes hold one target posture for a few samples, spaced so that the dwell
	// is reached about half the time; noise samples and time jumps break them up.
	task automatic run_random(input int count, input int pressure_at);
		int made;
		int len;
		int r;
		int x;
		int y;
		int z;
		int unsigned span;
		int unsigned step_cap;
		posture_t target;
		made = 0;
		while (made < count) begin
			target = posture_t'($urandom_range(1, 6));
			len = $urandom_range(1, 6);
			span = (target == POS_SIDE) ? int'(sb.side_dwell) : int'(sb.dwell);
			step_cap = span * 3 / 2 / ((len > 1) ? len - 1 : 1) + 1;
			for (int k = 0; k < len && made < count; k++) begin
				r = $urandom_range(0, 99);
				if (r < 2)
					now_us = {$urandom, $urandom};
				else if (r < 3)
					now_us = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 2000000);
				else if (r < 5)
					now_us = now_us - $urandom_range(1, 5000);
				else
					now_us = now_us + $urandom_range(0, step_cap);
				if ($urandom_range(0, 99) < 12) begin
					x = $urandom_range(0, 65535);
					y = $urandom_range(0, 65535);
					z = $urandom_range(0, 65535);
				end else begin
					shape_sample(target, x, y, z);
				end
				if (made == pressure_at)
					hold_asked = 1'b1;
				feed_sample(x, y, z, now_us);
				made++;
			end
		end
	endtask

	task automatic run_directed();
		// Side commit straight out of unknown reports no event.
		feed_sample(32767, 0, 0, 64'd0);
		feed_sample(32767, 0, 0, 64'd999999);
		feed_sample(32767, 0, 0, 64'd1000000);
		// Flat back committed exactly at the dwell boundary.
		feed_sample(0, 0, -32768, 64'd1100000);
		feed_sample(0, 0, -32768, 64'd1449999);
		feed_sample(0, 0, -32768, 64'd1450000);
		// Flat hold at the exit level, then drop below it.
		feed_sample(0, 0, -3072, 64'd1500000);
		feed_sample(0, 0, -3071, 64'd1600000);
		feed_sample(4000, 4000, 0, 64'd1950000);
		// Not flat any more, so the enter level applies again.
		feed_sample(0, 0, 3481, 64'd2000000);
		feed_sample(0, 0, 3482, 64'd2100000);
		feed_sample(0, 32767, 0, 64'd2200000);
		feed_sample(0, 32767, 0, 64'd2550000);
		feed_sample(-32768, -32767, 0, 64'd2600000);
		feed_sample(-32768, -32767, 0, 64'd3600000);
		feed_sample(5, 32767, 0, 64'd3700000);
		feed_sample(5, 32767, 0, 64'd4050000);
		feed_sample(-32767, -32768, 0, 64'd4100000);
		feed_sample(-32767, -32768, 0, 64'd4450000);
		feed_sample(0, 0, 32767, 64'd4500000);
		feed_sample(0, 0, 32767, 64'd4850000);
		// A timestamp one microsecond in the past wraps and commits.
		feed_sample(0, -4096, 0, 64'd4900000);
		feed_sample(0, -4096, 0, 64'd4899999);
		// Dwell measured across the 64-bit wrap of the timestamp.
		feed_sample(-4096, 0, 0, 64'hFFFF_FFFF_FFFF_FFF0);
		feed_sample(-4096, 0, 0, 64'h0000_0000_000F_4230);
		now_us = 64'h0000_0000_000F_4230;
	endtask

	task automatic random_levels();
		logic [CFG_DATA_W-1:0] lvl[4];
		logic [CFG_DATA_W-1:0] dw[2];
		foreach (lvl[i])
			lvl[i] = {9'($urandom), ($urandom_range(0, 1) ?
				15'($urandom_range(1500, 9000)) : 15'($urandom))};
		foreach (dw[i])
			dw[i] = ($urandom_range(0, 7) == 0) ? '0 : 24'($urandom_range(1, 2000000));
		set_thresholds(lvl[0], lvl[1], lvl[2], lvl[3], dw[0], dw[1]);
	endtask

	initial begin : receiver
		int n;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (holding()) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_served = 1'b1;
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			n = idle_len();
			if (n > 0) begin
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		// Every level masked down to zero, zero dwell; spare indexes must be ignored.
		set_thresholds(24'hFF8000, 24'hFF8000, 24'hFF8000, 24'hFF8000, 24'h000000, 24'h000000);
		@(posedge clk);
		write_reg(REG_SPARE_LO, 24'hFFFFFF);
		write_reg(REG_SPARE_HI, 24'h5A5A5A);
		cfg_valid <= 1'b0;
		run_random(200, -1);

		set_thresholds(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		run_random(250, -1);

		set_thresholds(24'(FLAT_ENTER_RST), 24'(FLAT_EXIT_RST), 24'(VERTICAL_RST),
			24'(SIDE_RST), DWELL_RST, SIDE_DWELL_RST);
		run_random(350, 150);

		repeat (3) begin
			random_levels();
			run_random(330, -1);
		end

		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
